// File: hw/rtl/tsrm_pkg.sv
`timescale 1ns / 1ps

package tsrm_pkg;

  localparam int TEMP_W     = 16;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_COUNT   = 1'd1;

  localparam logic [7:0]               MARKER_VALID  = 8'd170;
  localparam logic signed [TEMP_W-1:0] MEAN_LIMIT    = 16'sd850;
  localparam logic signed [TEMP_W-1:0] FAIL_VALUE    = 16'sd1990;
  localparam logic signed [TEMP_W-1:0] NO_MEAN_VALUE = 16'sd1900;
  localparam logic [1:0]               MAX_TRIES     = 2'd3;
  localparam logic [7:0]               CRC_POLY      = 8'h8C;
  localparam int                       FRAC_SHIFT    = 4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CRC  = 6'b000010,
    S_UPD  = 6'b000100,
    S_MEAN = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  // One byte of the reflected 1-Wire CRC8, least significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/temp_sensor_readout_and_mean_unit.sv
`timescale 1ns / 1ps

// Temperature sensor readout with a running mean of the stored values.
// The in_ channel takes one scratchpad word per reading of the sensor now
// being polled; the out_ channel returns one result word for each of them.
// The cfg_ channel writes the sensor count (index 0) and the mean count
// (index 1); it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. A word passes through the
// byte-serial CRC, then the conversion and storing of the value, then the
// reads of the first mean_count stored values from the memory, and then the
// bit-serial divider, which does no division when no value qualifies. The
// result is then loaded into the output register and the block returns to
// idle, so one word is in flight at a time.
// The next input word is taken while a finished result still waits in the
// output register; when the receiver stalls, the following result waits in
// the block and in_tready stays low until it can be loaded.
// Reset clears the sensor pointer, retry count, fail bits, the mean flag,
// the valid bits of the value store (so every entry reads as zero), and sets
// both counts to one.
module temp_sensor_readout_and_mean_unit #(
  parameter int MAX_SENSORS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // temp_low_byte, temp_high_byte, marker_byte, offset_byte, pad_byte4,
  // pad_byte5, pad_byte6, pad_byte7, check_byte.
  input  logic [tsrm_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // sensor_index, temperature, fail_mask, mean_temp, mean_fail, zero fill.
  output logic [tsrm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // crc_ok, advanced.
  output logic [tsrm_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);
  localparam int SUM_W = tsrm_pkg::TEMP_W + CNT_W;
  localparam int DC_W  = $clog2(SUM_W + 1);

  tsrm_pkg::state_t state_r, state_nxt;

  logic [tsrm_pkg::CFG_DATA_W-1:0] sc_r, sc_nxt;
  logic [tsrm_pkg::CFG_DATA_W-1:0] mc_r, mc_nxt;
  logic [IDX_W-1:0]                cur_r, cur_nxt;
  logic [1:0]                      retry_r, retry_nxt;
  logic signed [15:0]              last_r, last_nxt;
  logic [7:0]                      fail_r, fail_nxt;
  logic                            avg_fail_r, avg_fail_nxt;
  logic [MAX_SENSORS-1:0]          valid_r, valid_nxt;
  logic [2:0]                      bc_r, bc_nxt;
  logic [CNT_W-1:0]                ra_r, ra_nxt;
  logic                            pend_r, pend_nxt;
  logic [CNT_W-1:0]                n_r, n_nxt;
  logic [DC_W-1:0]                 dc_r, dc_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic [tsrm_pkg::IN_DATA_W-1:0]  in_data_r, in_data_nxt;
  logic [7:0]                      crc_r, crc_nxt;
  logic signed [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SUM_W-1:0]                quo_r, quo_nxt;
  logic [CNT_W-1:0]                rem_r, rem_nxt;
  logic                            neg_r, neg_nxt;
  logic [2:0]                      res_idx_r, res_idx_nxt;
  logic signed [15:0]              res_temp_r, res_temp_nxt;
  logic                            res_ok_r, res_ok_nxt;
  logic                            res_adv_r, res_adv_nxt;
  logic                            res_done_r, res_done_nxt;
  logic [tsrm_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [tsrm_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                            out_last_r, out_last_nxt;

  logic signed [15:0] store_mem [MAX_SENSORS];
  logic signed [15:0] rd_data_r;
  logic               rd_vld_r;
  logic               rd_en;
  logic               wr_en;
  logic signed [15:0] wr_data;

  logic               in_acc;
  logic [7:0]         b_lo, b_hi, b_mark, b_off, b_chk;
  logic signed [15:0] raw;
  logic signed [16:0] raw_ext;
  logic [16:0]        mag;
  logic [19:0]        prod;
  logic [15:0]        scaled;
  logic signed [16:0] conv;
  logic signed [16:0] conv_adj;
  logic               crc_ok;
  logic [1:0]         retry_inc;
  logic [CNT_W-1:0]   count_sat;
  logic [CNT_W-1:0]   mean_sat;
  logic [CNT_W-1:0]   next_idx;
  logic signed [15:0] rd_val;
  logic [CNT_W:0]     rem_sh;
  logic               q_bit;
  logic signed [15:0] quo_s;
  logic signed [15:0] mean_val;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == tsrm_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign b_lo   = in_data_r[7:0];
  assign b_hi   = in_data_r[15:8];
  assign b_mark = in_data_r[23:16];
  assign b_off  = in_data_r[31:24];
  assign b_chk  = in_data_r[71:64];

  assign raw      = signed'({b_hi, b_lo});
  assign raw_ext  = 17'(raw);
  assign mag      = raw[15] ? 17'(-raw_ext) : 17'(raw_ext);
  assign prod     = {mag, 3'b000} + {2'b00, mag, 1'b0};
  assign scaled   = prod[tsrm_pkg::FRAC_SHIFT +: 16];
  assign conv     = raw[15] ? -signed'({1'b0, scaled}) : signed'({1'b0, scaled});
  assign conv_adj = (b_mark == tsrm_pkg::MARKER_VALID) ?
                    conv + 17'(signed'(b_off)) : conv;
  assign crc_ok   = (crc_r == b_chk);
  assign retry_inc = retry_r + 2'd1;

  assign count_sat = (sc_r == '0) ? CNT_W'(1) :
                     (sc_r > MAX_SENSORS) ? CNT_W'(MAX_SENSORS) : CNT_W'(sc_r);
  assign mean_sat  = (mc_r > MAX_SENSORS) ? CNT_W'(MAX_SENSORS) : CNT_W'(mc_r);
  assign next_idx  = CNT_W'(cur_r) + CNT_W'(1);

  assign rd_val = rd_vld_r ? rd_data_r : '0;
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, n_r});

  assign quo_s    = signed'(quo_r[15:0]);
  assign mean_val = (n_r == '0) ? tsrm_pkg::NO_MEAN_VALUE : (neg_r ? -quo_s : quo_s);

  assign rd_en = (state_r == tsrm_pkg::S_MEAN) && (ra_r < mean_sat);

  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    mc_nxt        = mc_r;
    cur_nxt       = cur_r;
    retry_nxt     = retry_r;
    last_nxt      = last_r;
    fail_nxt      = fail_r;
    avg_fail_nxt  = avg_fail_r;
    valid_nxt     = valid_r;
    bc_nxt        = bc_r;
    ra_nxt        = ra_r;
    pend_nxt      = pend_r;
    n_nxt         = n_r;
    dc_nxt        = dc_r;
    out_valid_nxt = out_valid_r;
    in_data_nxt   = in_data_r;
    crc_nxt       = crc_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    res_idx_nxt   = res_idx_r;
    res_temp_nxt  = res_temp_r;
    res_ok_nxt    = res_ok_r;
    res_adv_nxt   = res_adv_r;
    res_done_nxt  = res_done_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_data       = '0;

    if (cfg_valid) begin
      case (cfg_index)
        tsrm_pkg::REG_SENSOR_COUNT: sc_nxt = cfg_data;
        tsrm_pkg::REG_MEAN_COUNT:   mc_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tsrm_pkg::S_IDLE: begin
        if (in_acc) begin
          in_data_nxt = in_tdata;
          crc_nxt     = '0;
          bc_nxt      = '0;
          state_nxt   = tsrm_pkg::S_CRC;
        end
      end
      tsrm_pkg::S_CRC: begin
        crc_nxt = tsrm_pkg::crc8_byte(crc_r, in_data_r[bc_r*8 +: 8]);
        bc_nxt  = bc_r + 3'd1;
        if (bc_r == 3'd7) begin
          state_nxt = tsrm_pkg::S_UPD;
        end
      end
      tsrm_pkg::S_UPD: begin
        if (crc_ok) begin
          retry_nxt = '0;
          wr_data   = conv_adj[15:0];
        end else if (retry_inc >= tsrm_pkg::MAX_TRIES) begin
          retry_nxt = '0;
          wr_data   = tsrm_pkg::FAIL_VALUE;
          fail_nxt  = fail_r | (8'd1 << cur_r);
        end else begin
          retry_nxt = retry_inc;
          wr_data   = last_r;
        end
        wr_en            = 1'b1;
        valid_nxt[cur_r] = 1'b1;
        last_nxt         = wr_data;
        res_idx_nxt      = 3'(cur_r);
        res_temp_nxt     = wr_data;
        res_ok_nxt       = crc_ok;
        res_adv_nxt      = (retry_nxt == '0);
        res_done_nxt     = 1'b0;
        if (retry_nxt == '0) begin
          if (next_idx >= count_sat) begin
            cur_nxt      = '0;
            res_done_nxt = 1'b1;
          end else begin
            cur_nxt = next_idx[IDX_W-1:0];
          end
        end
        ra_nxt    = '0;
        pend_nxt  = 1'b0;
        sum_nxt   = '0;
        n_nxt     = '0;
        state_nxt = tsrm_pkg::S_MEAN;
      end
      tsrm_pkg::S_MEAN: begin
        if (pend_r && (rd_val < tsrm_pkg::MEAN_LIMIT)) begin
          sum_nxt = sum_r + SUM_W'(rd_val);
          n_nxt   = n_r + CNT_W'(1);
        end
        pend_nxt = rd_en;
        if (rd_en) begin
          ra_nxt = ra_r + CNT_W'(1);
        end
        if (!pend_r && !rd_en) begin
          rem_nxt   = '0;
          neg_nxt   = sum_r[SUM_W-1];
          quo_nxt   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
          dc_nxt    = '0;
          state_nxt = tsrm_pkg::S_DIV;
        end
      end
      tsrm_pkg::S_DIV: begin
        if (n_r == '0) begin
          avg_fail_nxt = 1'b1;
          state_nxt    = tsrm_pkg::S_OUT;
        end else begin
          rem_nxt = q_bit ? CNT_W'(rem_sh - {1'b0, n_r}) : rem_sh[CNT_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], q_bit};
          dc_nxt  = dc_r + DC_W'(1);
          if (dc_r == DC_W'(SUM_W - 1)) begin
            state_nxt = tsrm_pkg::S_OUT;
          end
        end
      end
      tsrm_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, avg_fail_r, mean_val, fail_r, res_temp_r, res_idx_r};
          out_user_nxt  = {res_adv_r, res_ok_r};
          out_last_nxt  = res_done_r;
          state_nxt     = tsrm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsrm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsrm_pkg::S_IDLE;
      sc_r        <= tsrm_pkg::CFG_DATA_W'(1);
      mc_r        <= tsrm_pkg::CFG_DATA_W'(1);
      cur_r       <= '0;
      retry_r     <= '0;
      last_r      <= '0;
      fail_r      <= '0;
      avg_fail_r  <= 1'b0;
      valid_r     <= '0;
      bc_r        <= '0;
      ra_r        <= '0;
      pend_r      <= 1'b0;
      n_r         <= '0;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      mc_r        <= mc_nxt;
      cur_r       <= cur_nxt;
      retry_r     <= retry_nxt;
      last_r      <= last_nxt;
      fail_r      <= fail_nxt;
      avg_fail_r  <= avg_fail_nxt;
      valid_r     <= valid_nxt;
      bc_r        <= bc_nxt;
      ra_r        <= ra_nxt;
      pend_r      <= pend_nxt;
      n_r         <= n_nxt;
      dc_r        <= dc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    crc_r      <= crc_nxt;
    sum_r      <= sum_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    res_idx_r  <= res_idx_nxt;
    res_temp_r <= res_temp_nxt;
    res_ok_r   <= res_ok_nxt;
    res_adv_r  <= res_adv_nxt;
    res_done_r <= res_done_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[cur_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[ra_r[IDX_W-1:0]];
      rd_vld_r  <= valid_r[ra_r[IDX_W-1:0]];
    end
  end

  a_accept_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == tsrm_pkg::S_CRC))
    else $error("accepted word did not start the CRC pass");

  a_count_within_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsrm_pkg::S_MEAN) |-> (n_r <= ra_r))
    else $error("qualifying count exceeds the reads issued");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tsrm_pkg::S_DIV) && (n_r != '0)) |-> (rem_r < n_r))
    else $error("divider remainder not below divisor");

  a_retry_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r != tsrm_pkg::MAX_TRIES)
    else $error("retry count reached the try limit");

  a_mean_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(avg_fail_r)) |-> avg_fail_r)
    else $error("mean fail flag cleared outside reset");

  a_fail_bits_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((fail_r & $past(fail_r)) == $past(fail_r)))
    else $error("sensor fail bit cleared outside reset");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_SENSORS  = 8;
  localparam int SETTLE_WAIT  = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_WORDS  = 165;

  typedef struct {
    logic [2:0]         sensor;
    logic signed [15:0] temp;
    logic               crc_ok;
    logic               advanced;
    logic               round_done;
    logic [7:0]         fail_mask;
    logic signed [15:0] mean;
    logic               mean_fail;
  } readout_t;

  class readout_predictor;
    int unsigned sensors_reg;
    int unsigned mean_reg;
    int unsigned cur_sensor;
    int unsigned retries;
    int          stored[NUM_SENSORS];
    int          last_val;
    logic [7:0]  fail_bits;
    logic        mean_flag;
    readout_t    expected_readouts[$];
    int          errors;

    function new();
      sensors_reg = 1;
      mean_reg = 1;
      cur_sensor = 0;
      retries = 0;
      foreach (stored[i]) stored[i] = 0;
      last_val = 0;
      fail_bits = '0;
      mean_flag = 1'b0;
      errors = 0;
    endfunction

    static function logic [7:0] crc_of(input logic [63:0] scratch);
      logic [7:0] crc;
      logic [7:0] b;
      logic       mix;
      crc = '0;
      for (int i = 0; i < 8; i++) begin
        b = scratch[8*i +: 8];
        for (int k = 0; k < 8; k++) begin
          mix = crc[0] ^ b[0];
          crc = crc >> 1;
          if (mix) begin
            crc = crc ^ tsrm_pkg::CRC_POLY;
          end
          b = b >> 1;
        end
      end
      return crc;
    endfunction

    function void set_reg(input logic [tsrm_pkg::CFG_IDX_W-1:0] idx,
                          input logic [tsrm_pkg::CFG_DATA_W-1:0] v);
      if (idx == tsrm_pkg::REG_SENSOR_COUNT) begin
        sensors_reg = v;
      end else if (idx == tsrm_pkg::REG_MEAN_COUNT) begin
        mean_reg = v;
      end
    endfunction

    function int pending();
      return expected_readouts.size();
    endfunction

    function void note_reading(input logic [71:0] w);
      readout_t    r;
      int unsigned count;
      int unsigned idx;
      int unsigned nxt;
      int unsigned mc;
      int          raw;
      int          offs;
      int          val;
      int          sum;
      int          n;
      logic        ok;
      count = sensors_reg;
      if (count == 0) begin
        count = 1;
      end
      if (count > NUM_SENSORS) begin
        count = NUM_SENSORS;
      end
      idx = cur_sensor % NUM_SENSORS;
      ok = (crc_of(w[63:0]) == w[71:64]);
      if (ok) begin
        retries = 0;
        raw = $signed(w[15:0]);
        if (raw < 0) begin
          val = -((-raw) * 10 / 16);
        end else begin
          val = raw * 10 / 16;
        end
        if (w[23:16] == tsrm_pkg::MARKER_VALID) begin
          offs = $signed(w[31:24]);
          val = val + offs;
        end
      end else begin
        retries++;
        if (retries >= tsrm_pkg::MAX_TRIES) begin
          val = tsrm_pkg::FAIL_VALUE;
          retries = 0;
          fail_bits[idx] = 1'b1;
        end else begin
          val = last_val;
        end
      end
      stored[idx] = val;
      last_val = val;
      r.round_done = 1'b0;
      r.advanced = (retries == 0);
      if (r.advanced) begin
        nxt = idx + 1;
        if (nxt >= count) begin
          nxt = 0;
          r.round_done = 1'b1;
        end
        cur_sensor = nxt;
      end
      mc = (mean_reg > NUM_SENSORS) ? NUM_SENSORS : mean_reg;
      sum = 0;
      n = 0;
      for (int i = 0; i < mc; i++) begin
        if (stored[i] < tsrm_pkg::MEAN_LIMIT) begin
          sum += stored[i];
          n++;
        end
      end
      if (n > 0) begin
        r.mean = sum / n;
      end else begin
        r.mean = tsrm_pkg::NO_MEAN_VALUE;
        mean_flag = 1'b1;
      end
      r.sensor = idx[2:0];
      r.temp = val;
      r.crc_ok = ok;
      r.fail_mask = fail_bits;
      r.mean_fail = mean_flag;
      expected_readouts.push_back(r);
    endfunction

    function void report(input string field, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_readout(input logic [tsrm_pkg::OUT_DATA_W-1:0] d,
                                input logic [tsrm_pkg::OUT_USER_W-1:0] u, input logic l);
      readout_t r;
      if (expected_readouts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, d);
        return;
      end
      r = expected_readouts.pop_front();
      report("sensor_index", r.sensor, d[2:0]);
      report("temperature", r.temp, $signed(d[18:3]));
      report("fail_mask", r.fail_mask, d[26:19]);
      report("mean_temp", r.mean, $signed(d[42:27]));
      report("mean_fail", r.mean_fail, d[43]);
      report("zero fill", 0, d[47:44]);
      report("crc_ok", r.crc_ok, u[0]);
      report("advanced", r.advanced, u[1]);
      report("round_done", r.round_done, l);
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [tsrm_pkg::IN_DATA_W-1:0]   in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tsrm_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic [tsrm_pkg::OUT_USER_W-1:0]  out_tuser;
  logic                             out_tlast;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tsrm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tsrm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  readout_predictor sb = new();
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  int               quiet = 0;

  temp_sensor_readout_and_mean_unit #(.MAX_SENSORS(NUM_SENSORS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_readout(out_tdata, out_tuser, out_tlast);
    end
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("temp_sensor_readout_and_mean_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [71:0] make_word(input logic [15:0] raw, input logic [7:0] marker,
                                            input logic [7:0] offs, input bit good);
    logic [71:0] w;
    logic [7:0]  crc;
    w[15:0] = raw;
    w[23:16] = marker;
    w[31:24] = offs;
    w[63:32] = $urandom;
    crc = readout_predictor::crc_of(w[63:0]);
    w[71:64] = good ? crc : crc ^ 8'($urandom_range(1, 255));
    return w;
  endfunction

  task automatic send_reading(input logic [71:0] w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_reading(w);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_counts(input logic [3:0] sensors, input logic [3:0] means);
    cfg_valid <= 1'b1;
    cfg_index <= tsrm_pkg::REG_SENSOR_COUNT;
    cfg_data <= sensors;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(tsrm_pkg::REG_SENSOR_COUNT, sensors);
    cfg_index <= tsrm_pkg::REG_MEAN_COUNT;
    cfg_data <= means;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(tsrm_pkg::REG_MEAN_COUNT, means);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_reading(inout int bad_run);
    int          kind;
    int          raw;
    logic [7:0]  marker;
    bit          good;
    logic [71:0] w;
    kind = $urandom_range(0, 9);
    if (bad_run == 0 && $urandom_range(0, 24) == 0) begin
      bad_run = 3;
    end
    marker = $urandom_range(0, 1) ? tsrm_pkg::MARKER_VALID : 8'($urandom);
    if (kind < 7) begin
      raw = int'($urandom_range(0, 2880)) - 880;
      good = (bad_run == 0) && ($urandom_range(0, 6) != 0);
      w = make_word(raw[15:0], marker, 8'($urandom), good);
    end else if (kind < 9) begin
      good = (bad_run == 0) && ($urandom_range(0, 1) != 0);
      w = make_word(16'($urandom), marker, 8'($urandom), good);
    end else begin
      w = {8'($urandom), $urandom, $urandom};
    end
    if (bad_run > 0) begin
      bad_run--;
    end
    send_reading(w);
  endtask

  initial begin
    logic [3:0] sensor_sel[8];
    logic [3:0] mean_sel[8];
    int         bad_run;
    sensor_sel = '{4'd8, 4'd15, 4'd3, 4'd0, 4'd5, 4'd1, 4'd7, 4'd2};
    mean_sel   = '{4'd8, 4'd0, 4'd15, 4'd4, 4'd1, 4'd9, 4'd3, 4'd6};
    bad_run = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_reading(make_word(16'h0000, 8'h00, 8'h00, 1'b0));
    send_reading(make_word(16'h0000, 8'h00, 8'h00, 1'b0));
    send_reading(make_word(16'h0000, 8'h00, 8'h00, 1'b0));
    send_reading(make_word(16'h7FFF, tsrm_pkg::MARKER_VALID, 8'h7F, 1'b1));
    send_reading(make_word(16'h8000, tsrm_pkg::MARKER_VALID, 8'h80, 1'b1));
    send_reading(make_word(16'hFFFF, 8'h00, 8'hFF, 1'b1));
    send_reading(make_word(16'hFFF8, 8'hFF, 8'h10, 1'b1));
    send_reading(make_word(16'd1360, 8'd169, 8'h05, 1'b1));
    send_reading(make_word(16'd1359, tsrm_pkg::MARKER_VALID, 8'h00, 1'b1));
    drain();
    write_counts(4'd8, 4'd8);
    send_reading(make_word(16'd400, tsrm_pkg::MARKER_VALID, 8'hF6, 1'b1));
    send_reading(make_word(16'hFC90, 8'h00, 8'h00, 1'b1));
    send_reading(make_word(16'd2000, 8'h00, 8'h00, 1'b1));
    send_reading(make_word(16'd1, 8'h00, 8'h00, 1'b0));
    send_reading(make_word(16'd16, 8'h00, 8'h00, 1'b1));
    send_reading(make_word(16'd800, tsrm_pkg::MARKER_VALID, 8'h32, 1'b1));
    drain();
    // Lowering the count below the current sensor finishes it and wraps.
    write_counts(4'd2, 4'd0);
    send_reading(make_word(16'd500, 8'h00, 8'h00, 1'b1));
    send_reading(make_word(16'd300, 8'h00, 8'h00, 1'b1));
    drain();
    write_counts(4'd0, 4'd15);
    send_reading(make_word(16'd100, 8'h00, 8'h00, 1'b1));
    send_reading(make_word(16'd200, 8'h00, 8'h00, 1'b1));
    drain();
    write_counts(4'd15, 4'd9);
    send_reading(make_word(16'd250, 8'h00, 8'h00, 1'b1));
    send_reading(make_word(16'hFFFF, 8'hFF, 8'hFF, 1'b0));
    send_reading(make_word(16'd0, 8'h00, 8'h00, 1'b1));

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      write_counts(sensor_sel[phase], mean_sel[phase]);
      if (phase == 7) begin
        idle_on = 1'b0;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (phase == 3 && i == 80) begin
          drain();
        end
        send_random_reading(bad_run);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("temp_sensor_readout_and_mean_unit regression: pass");
    end else begin
      $display("temp_sensor_readout_and_mean_unit regression: fail");
    end
    $finish;
  end

endmodule
